[src/fca_pkg.sv]
package fca_pkg;

  localparam int ENTRIES_DEF = 256;
  localparam int MAX_CHAIN   = 16;

  localparam int LINK_W = 16;
  localparam int LEN_W  = 5;
  localparam int CNT_W  = 9;

  localparam logic [LINK_W-1:0] LINK_FREE = 16'hFFFF;
  localparam logic [LINK_W-1:0] LINK_END  = 16'hFFFE;
  localparam logic [LINK_W-1:0] NO_SECTOR = 16'hFFFF;

  typedef enum logic [2:0] {
    MODE_ALLOC  = 3'd0,
    MODE_FREE   = 3'd1,
    MODE_NEXT   = 3'd2,
    MODE_LOAD   = 3'd3,
    MODE_FORMAT = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NO_SPACE  = 2'd1,
    STAT_TOO_LONG  = 2'd2,
    STAT_BAD_INDEX = 2'd3
  } status_t;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CLAIM_RD,
    ST_CLAIM_WT,
    ST_CLAIM_END,
    ST_SRCH_RD,
    ST_SRCH_WT,
    ST_WALK_CHK,
    ST_WALK_WT,
    ST_EMIT_RD,
    ST_EMIT_WT,
    ST_EMIT_OUT,
    ST_FREE_RD,
    ST_FREE_WT,
    ST_NEXT_WT,
    ST_LOAD_WT,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic [LINK_W-1:0] sector;
    status_t           status;
    logic              last;
  } res_t;

endpackage

[src/fca_link_mem.sv]
module fca_link_mem #(
  parameter int ENTRIES = fca_pkg::ENTRIES_DEF,
  localparam int AW = $clog2(ENTRIES)
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [AW-1:0]              waddr,
  input  logic [fca_pkg::LINK_W-1:0] wdata,
  input  logic                       re,
  input  logic [AW-1:0]              raddr,
  output logic [fca_pkg::LINK_W-1:0] rdata
);

  logic [fca_pkg::LINK_W-1:0] mem [ENTRIES];
  logic [fca_pkg::LINK_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[src/fca_seq.sv]
module fca_seq #(
  parameter int ENTRIES = fca_pkg::ENTRIES_DEF,
  localparam int AW = $clog2(ENTRIES),
  localparam int FW = $clog2(ENTRIES + 1)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [2:0]                 in_mode,
  input  logic [15:0]                in_sector,
  input  logic [4:0]                 in_length,
  input  logic [15:0]                in_value,
  output logic                       res_valid,
  input  logic                       res_ready,
  output fca_pkg::res_t              res,
  output logic [FW-1:0]              free_total,
  output logic                       mem_we,
  output logic [AW-1:0]              mem_waddr,
  output logic [fca_pkg::LINK_W-1:0] mem_wdata,
  output logic                       mem_re,
  output logic [AW-1:0]              mem_raddr,
  input  logic [fca_pkg::LINK_W-1:0] mem_rdata
);

  localparam int SW = AW + 1;
  localparam logic [15:0]   ENT16    = 16'(ENTRIES);
  localparam logic [AW-1:0] END_IDX  = AW'(ENTRIES - 1);
  localparam logic [FW-1:0] FREE_MAX = FW'(ENTRIES);

  fca_pkg::state_t state_r, state_nxt;
  logic [AW-1:0]   idx_r, idx_nxt;
  logic [AW-1:0]   prev_r, prev_nxt;
  logic [FW-1:0]   free_r, free_nxt;
  logic [fca_pkg::LEN_W-1:0] got_r, got_nxt;
  logic [fca_pkg::LEN_W-1:0] len_r, len_nxt;
  logic [SW-1:0]   steps_r, steps_nxt;
  logic [15:0]     cur_r, cur_nxt;
  logic [15:0]     value_r, value_nxt;
  logic            fmt_r, fmt_nxt;
  fca_pkg::res_t   res_r, res_nxt;

  logic            idx_last;
  logic [AW-1:0]   idx_inc;
  logic [fca_pkg::LEN_W-1:0] got_inc;
  logic            walk_stop;
  logic            walk_hit;

  assign idx_last  = (idx_r == END_IDX);
  assign idx_inc   = idx_r + AW'(1);
  assign got_inc   = got_r + fca_pkg::LEN_W'(1);
  assign walk_stop = (cur_r == 16'(prev_r)) || (cur_r >= ENT16) || (steps_r >= SW'(got_r));
  assign walk_hit  = (cur_r == 16'(prev_r)) &&
                     (steps_r == SW'(got_r - fca_pkg::LEN_W'(1)));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fca_pkg::ST_CLEAR;
      idx_r   <= '0;
      fmt_r   <= 1'b0;
      free_r  <= FREE_MAX;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      fmt_r   <= fmt_nxt;
      free_r  <= free_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prev_r  <= prev_nxt;
    got_r   <= got_nxt;
    len_r   <= len_nxt;
    steps_r <= steps_nxt;
    cur_r   <= cur_nxt;
    value_r <= value_nxt;
    res_r   <= res_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    prev_nxt  = prev_r;
    free_nxt  = free_r;
    got_nxt   = got_r;
    len_nxt   = len_r;
    steps_nxt = steps_r;
    cur_nxt   = cur_r;
    value_nxt = value_r;
    fmt_nxt   = fmt_r;
    res_nxt   = res_r;
    mem_we    = 1'b0;
    mem_waddr = idx_r;
    mem_wdata = fca_pkg::LINK_FREE;
    mem_re    = 1'b0;
    mem_raddr = idx_r;

    case (state_r)
      fca_pkg::ST_CLEAR: begin
        mem_we = 1'b1;
        if (idx_last) begin
          free_nxt = FREE_MAX;
          res_nxt  = '{sector: fca_pkg::NO_SECTOR, status: fca_pkg::STAT_OK, last: 1'b1};
          state_nxt = fmt_r ? fca_pkg::ST_RESULT : fca_pkg::ST_IDLE;
          fmt_nxt  = 1'b0;
        end else begin
          idx_nxt = idx_inc;
        end
      end

      fca_pkg::ST_IDLE: begin
        res_nxt   = '{sector: fca_pkg::NO_SECTOR, status: fca_pkg::STAT_OK, last: 1'b1};
        cur_nxt   = in_sector;
        value_nxt = in_value;
        steps_nxt = '0;
        mem_raddr = in_sector[AW-1:0];
        if (in_valid) begin
          case (in_mode)
            fca_pkg::MODE_ALLOC: begin
              if (in_length == '0) begin
                state_nxt = fca_pkg::ST_RESULT;
              end else if (32'(in_length) > fca_pkg::MAX_CHAIN) begin
                res_nxt.status = fca_pkg::STAT_TOO_LONG;
                state_nxt = fca_pkg::ST_RESULT;
              end else if (16'(in_length) > 16'(free_r)) begin
                res_nxt.status = fca_pkg::STAT_NO_SPACE;
                state_nxt = fca_pkg::ST_RESULT;
              end else begin
                len_nxt   = in_length;
                got_nxt   = '0;
                idx_nxt   = '0;
                state_nxt = fca_pkg::ST_CLAIM_RD;
              end
            end
            fca_pkg::MODE_FREE: begin
              if (in_sector < ENT16) begin
                mem_re    = 1'b1;
                state_nxt = fca_pkg::ST_FREE_WT;
              end else begin
                if (in_sector != fca_pkg::LINK_FREE && in_sector != fca_pkg::LINK_END) begin
                  res_nxt.status = fca_pkg::STAT_BAD_INDEX;
                end
                state_nxt = fca_pkg::ST_RESULT;
              end
            end
            fca_pkg::MODE_NEXT, fca_pkg::MODE_LOAD: begin
              if (in_sector < ENT16) begin
                mem_re    = 1'b1;
                state_nxt = (in_mode == fca_pkg::MODE_NEXT) ? fca_pkg::ST_NEXT_WT
                                                            : fca_pkg::ST_LOAD_WT;
              end else begin
                res_nxt.status = fca_pkg::STAT_BAD_INDEX;
                state_nxt = fca_pkg::ST_RESULT;
              end
            end
            fca_pkg::MODE_FORMAT: begin
              idx_nxt   = '0;
              fmt_nxt   = 1'b1;
              state_nxt = fca_pkg::ST_CLEAR;
            end
            default: begin
              // unknown mode: drop the item, no result
            end
          endcase
        end
      end

      fca_pkg::ST_CLAIM_RD: begin
        mem_re    = 1'b1;
        state_nxt = fca_pkg::ST_CLAIM_WT;
      end

      fca_pkg::ST_CLAIM_WT: begin
        if (mem_rdata == fca_pkg::LINK_FREE) begin
          // link the previous claim to this one; the tail gets its end mark later
          mem_we    = (got_r != '0);
          mem_waddr = prev_r;
          mem_wdata = 16'(idx_r);
          prev_nxt  = idx_r;
          got_nxt   = got_inc;
          free_nxt  = free_r - FW'(1);
        end
        if ((mem_rdata == fca_pkg::LINK_FREE) && (got_inc == len_r)) begin
          state_nxt = fca_pkg::ST_CLAIM_END;
        end else if (idx_last) begin
          state_nxt = ((mem_rdata == fca_pkg::LINK_FREE) || (got_r != '0)) ?
                      fca_pkg::ST_CLAIM_END : fca_pkg::ST_IDLE;
        end else begin
          idx_nxt   = idx_inc;
          state_nxt = fca_pkg::ST_CLAIM_RD;
        end
      end

      fca_pkg::ST_CLAIM_END: begin
        mem_we    = 1'b1;
        mem_waddr = prev_r;
        mem_wdata = fca_pkg::LINK_END;
        idx_nxt   = '0;
        state_nxt = fca_pkg::ST_SRCH_RD;
      end

      fca_pkg::ST_SRCH_RD: begin
        mem_re    = 1'b1;
        state_nxt = fca_pkg::ST_SRCH_WT;
      end

      fca_pkg::ST_SRCH_WT: begin
        if (mem_rdata != fca_pkg::LINK_FREE) begin
          cur_nxt   = 16'(idx_r);
          steps_nxt = '0;
          state_nxt = fca_pkg::ST_WALK_CHK;
        end else if (idx_last) begin
          cur_nxt   = '0;
          steps_nxt = '0;
          state_nxt = fca_pkg::ST_EMIT_RD;
        end else begin
          idx_nxt   = idx_inc;
          state_nxt = fca_pkg::ST_SRCH_RD;
        end
      end

      fca_pkg::ST_WALK_CHK: begin
        mem_raddr = cur_r[AW-1:0];
        if (!walk_stop) begin
          mem_re    = 1'b1;
          state_nxt = fca_pkg::ST_WALK_WT;
        end else if (walk_hit) begin
          cur_nxt   = 16'(idx_r);
          steps_nxt = '0;
          state_nxt = fca_pkg::ST_EMIT_RD;
        end else if (idx_last) begin
          cur_nxt   = '0;
          steps_nxt = '0;
          state_nxt = fca_pkg::ST_EMIT_RD;
        end else begin
          idx_nxt   = idx_inc;
          state_nxt = fca_pkg::ST_SRCH_RD;
        end
      end

      fca_pkg::ST_WALK_WT: begin
        cur_nxt   = mem_rdata;
        steps_nxt = steps_r + SW'(1);
        state_nxt = fca_pkg::ST_WALK_CHK;
      end

      fca_pkg::ST_EMIT_RD: begin
        mem_raddr = cur_r[AW-1:0];
        mem_re    = (cur_r < ENT16);
        state_nxt = fca_pkg::ST_EMIT_WT;
      end

      fca_pkg::ST_EMIT_WT: begin
        value_nxt = (cur_r < ENT16) ? mem_rdata : cur_r;
        res_nxt   = '{sector: cur_r, status: fca_pkg::STAT_OK,
                      last: (steps_r == SW'(got_r - fca_pkg::LEN_W'(1)))};
        state_nxt = fca_pkg::ST_EMIT_OUT;
      end

      fca_pkg::ST_EMIT_OUT: begin
        if (res_ready) begin
          if (res_r.last) begin
            state_nxt = fca_pkg::ST_IDLE;
          end else begin
            cur_nxt   = value_r;
            steps_nxt = steps_r + SW'(1);
            state_nxt = fca_pkg::ST_EMIT_RD;
          end
        end
      end

      fca_pkg::ST_FREE_RD: begin
        mem_raddr = cur_r[AW-1:0];
        mem_re    = 1'b1;
        state_nxt = fca_pkg::ST_FREE_WT;
      end

      fca_pkg::ST_FREE_WT: begin
        if (mem_rdata == fca_pkg::LINK_FREE) begin
          state_nxt = fca_pkg::ST_RESULT;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = cur_r[AW-1:0];
          mem_wdata = fca_pkg::LINK_FREE;
          if (free_r < FREE_MAX) begin
            free_nxt = free_r + FW'(1);
          end
          cur_nxt   = mem_rdata;
          steps_nxt = steps_r + SW'(1);
          state_nxt = ((mem_rdata < ENT16) && ((steps_r + SW'(1)) < SW'(ENTRIES))) ?
                      fca_pkg::ST_FREE_RD : fca_pkg::ST_RESULT;
        end
      end

      fca_pkg::ST_NEXT_WT: begin
        res_nxt.sector = mem_rdata;
        state_nxt = fca_pkg::ST_RESULT;
      end

      fca_pkg::ST_LOAD_WT: begin
        mem_we    = 1'b1;
        mem_waddr = cur_r[AW-1:0];
        mem_wdata = value_r;
        if ((mem_rdata == fca_pkg::LINK_FREE) && (value_r != fca_pkg::LINK_FREE)) begin
          if (free_r != '0) begin
            free_nxt = free_r - FW'(1);
          end
        end else if ((mem_rdata != fca_pkg::LINK_FREE) &&
                     (value_r == fca_pkg::LINK_FREE)) begin
          if (free_r < FREE_MAX) begin
            free_nxt = free_r + FW'(1);
          end
        end
        state_nxt = fca_pkg::ST_RESULT;
      end

      fca_pkg::ST_RESULT: begin
        if (res_ready) begin
          state_nxt = fca_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = fca_pkg::ST_IDLE;
      end
    endcase
  end

  assign in_ready   = (state_r == fca_pkg::ST_IDLE);
  assign res_valid  = state_r inside {fca_pkg::ST_RESULT, fca_pkg::ST_EMIT_OUT};
  assign res        = res_r;
  assign free_total = free_r;

endmodule

[src/fat_chain_allocator.sv]
// From the input transfer to out_valid: a refused or empty allocate needs no table access, next
// and load read one entry, free releases entry by entry, format clears every entry, and allocate
// scans entries to claim, scans entries and walks links to find the head, then reads each sector.
// Items are taken one at a time; the next transfer is taken once the last result is loaded
// into the output register. Every step is paced by the single read port of the link memory.
// Reset: synchronous, active low; a clearing pass over the table frees every entry first.
module fat_chain_allocator #(
  parameter int ENTRIES = fca_pkg::ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_mode,
  input  logic [15:0] in_sector,
  input  logic [4:0]  in_length,
  input  logic [15:0] in_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_sector_out,
  output logic [1:0]  out_status,
  output logic [8:0]  out_free_count,
  output logic        out_last
);

  localparam int AW = $clog2(ENTRIES);
  localparam int FW = $clog2(ENTRIES + 1);

  // sequencer to output register
  logic          res_valid;
  logic          res_ready;
  fca_pkg::res_t res;
  logic [FW-1:0] free_total;

  // link memory port
  logic                       mem_we;
  logic [AW-1:0]              mem_waddr;
  logic [fca_pkg::LINK_W-1:0] mem_wdata;
  logic                       mem_re;
  logic [AW-1:0]              mem_raddr;
  logic [fca_pkg::LINK_W-1:0] mem_rdata;

  // output register
  logic        out_valid_r;
  logic [15:0] out_sector_r;
  logic [1:0]  out_status_r;
  logic [8:0]  out_free_r;
  logic        out_last_r;

  fca_seq #(
    .ENTRIES(ENTRIES)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_mode    (in_mode),
    .in_sector  (in_sector),
    .in_length  (in_length),
    .in_value   (in_value),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .free_total (free_total),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_re     (mem_re),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata)
  );

  fca_link_mem #(
    .ENTRIES(ENTRIES)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Take a new result whenever the register is empty or drains in this cycle.
  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Hold the payload until the transfer; the count shown is the one after the operation.
  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_sector_r <= res.sector;
      out_status_r <= res.status;
      out_free_r   <= 9'(free_total);
      out_last_r   <= res.last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sector_out = out_sector_r;
  assign out_status     = out_status_r;
  assign out_free_count = out_free_r;
  assign out_last       = out_last_r;

`ifndef ASSERT_OFF
  a_format_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_mode == fca_pkg::MODE_FORMAT)) |=> !in_ready)
    else $error("input taken during format sweep");

  a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res_ready) |-> (free_total <= FW'(ENTRIES)))
    else $error("free count above table size");

  a_chain_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |-> (out_status == fca_pkg::STAT_OK))
    else $error("non-final result with error status");
`endif

endmodule

[bench/fat_table_sb_pkg.sv]
`timescale 1ns / 100ps
package fat_table_sb_pkg;

  localparam int TABLE_SIZE = fca_pkg::ENTRIES_DEF;

  typedef struct packed {
    logic [fca_pkg::LINK_W-1:0] sector;
    fca_pkg::status_t           status;
    logic [fca_pkg::CNT_W-1:0]  count;
    logic                       last;
  } fat_result_t;

  class fat_table_scoreboard;
    logic [fca_pkg::LINK_W-1:0] links [TABLE_SIZE];
    int unsigned                free_total;
    fat_result_t                pending[$];
    int unsigned                mismatches;
    int                         last_head;

    function new();
      format_table();
      mismatches = 0;
      last_head  = -1;
    endfunction

    function void format_table();
      foreach (links[i]) links[i] = fca_pkg::LINK_FREE;
      free_total = TABLE_SIZE;
    endfunction

    function void push(logic [fca_pkg::LINK_W-1:0] sector, fca_pkg::status_t status,
                       logic last);
      fat_result_t r;
      r.sector = sector;
      r.status = status;
      r.count  = free_total[fca_pkg::CNT_W-1:0];
      r.last   = last;
      pending.push_back(r);
    endfunction

    // Apply one accepted transfer to the table and queue the results it causes.
    function void note_input(logic [2:0] mode, logic [fca_pkg::LINK_W-1:0] sector,
                             logic [fca_pkg::LEN_W-1:0] length,
                             logic [fca_pkg::LINK_W-1:0] value);
      int unsigned got, tail, head, walk, steps, s, nxt;
      last_head = -1;
      case (mode)
        fca_pkg::MODE_ALLOC: begin
          if (length == 0) begin
            push(fca_pkg::NO_SECTOR, fca_pkg::STAT_OK, 1'b1);
          end else if (length > fca_pkg::MAX_CHAIN) begin
            push(fca_pkg::NO_SECTOR, fca_pkg::STAT_TOO_LONG, 1'b1);
          end else if (length > free_total) begin
            push(fca_pkg::NO_SECTOR, fca_pkg::STAT_NO_SPACE, 1'b1);
          end else begin
            got  = 0;
            tail = 0;
            for (int i = 0; i < TABLE_SIZE && got < length; i++) begin
              if (links[i] == fca_pkg::LINK_FREE) begin
                if (got > 0) links[tail] = fca_pkg::LINK_W'(i);
                links[i] = fca_pkg::LINK_END;
                free_total--;
                tail = i;
                got++;
              end
            end
            // lowest used entry that reaches the tail in got-1 links
            head = 0;
            for (int k = 0; k < TABLE_SIZE; k++) begin
              if (links[k] != fca_pkg::LINK_FREE) begin
                walk  = k;
                steps = 0;
                while (walk != tail && walk < TABLE_SIZE && steps < got) begin
                  walk = links[walk];
                  steps++;
                end
                if (walk == tail && steps == got - 1) begin
                  head = k;
                  break;
                end
              end
            end
            last_head = head;
            s = head;
            for (int k = 0; k < got; k++) begin
              push(fca_pkg::LINK_W'(s), fca_pkg::STAT_OK, k + 1 == got);
              if (s < TABLE_SIZE) s = links[s];
            end
          end
        end
        fca_pkg::MODE_FREE: begin
          if (sector >= TABLE_SIZE && sector != fca_pkg::LINK_FREE &&
              sector != fca_pkg::LINK_END) begin
            push(fca_pkg::NO_SECTOR, fca_pkg::STAT_BAD_INDEX, 1'b1);
          end else begin
            s     = sector;
            steps = 0;
            while (s < TABLE_SIZE && steps < TABLE_SIZE) begin
              nxt = links[s];
              if (nxt == fca_pkg::LINK_FREE) break;
              links[s] = fca_pkg::LINK_FREE;
              if (free_total < TABLE_SIZE) free_total++;
              s = nxt;
              steps++;
            end
            push(fca_pkg::NO_SECTOR, fca_pkg::STAT_OK, 1'b1);
          end
        end
        fca_pkg::MODE_NEXT: begin
          if (sector >= TABLE_SIZE) push(fca_pkg::NO_SECTOR, fca_pkg::STAT_BAD_INDEX, 1'b1);
          else push(links[sector], fca_pkg::STAT_OK, 1'b1);
        end
        fca_pkg::MODE_LOAD: begin
          if (sector >= TABLE_SIZE) begin
            push(fca_pkg::NO_SECTOR, fca_pkg::STAT_BAD_INDEX, 1'b1);
          end else begin
            if (links[sector] == fca_pkg::LINK_FREE && value != fca_pkg::LINK_FREE) begin
              if (free_total > 0) free_total--;
            end else if (links[sector] != fca_pkg::LINK_FREE &&
                         value == fca_pkg::LINK_FREE) begin
              if (free_total < TABLE_SIZE) free_total++;
            end
            links[sector] = value;
            push(fca_pkg::NO_SECTOR, fca_pkg::STAT_OK, 1'b1);
          end
        end
        fca_pkg::MODE_FORMAT: begin
          format_table();
          push(fca_pkg::NO_SECTOR, fca_pkg::STAT_OK, 1'b1);
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic [fca_pkg::LINK_W-1:0] sector, logic [1:0] status,
                               logic [fca_pkg::CNT_W-1:0] count, logic last);
      fat_result_t want;
      if (pending.size() == 0) begin
        $error("unexpected result transfer: sector_out %h status %0d free_count %0d last %b",
               sector, status, count, last);
        mismatches++;
        return;
      end
      want = pending.pop_front();
      if (sector !== want.sector) begin
        $error("sector_out: expected %h, actual %h", want.sector, sector);
        mismatches++;
      end
      if (status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, status);
        mismatches++;
      end
      if (count !== want.count) begin
        $error("free_count: expected %0d, actual %0d", want.count, count);
        mismatches++;
      end
      if (last !== want.last) begin
        $error("last: expected %b, actual %b", want.last, last);
        mismatches++;
      end
    endfunction
  endclass

endpackage

[bench/tb_top.sv]
`timescale 1ns / 100ps
module tb_top;

  // Stop counting toward the random target here, and drop all idling near the end.
  localparam int ITEM_TARGET = 430;
  localparam int CALM_AFTER  = 380;
  // Drain window: a full format or a long free walk fits well inside it.
  localparam int DRAIN_CYCLES = 4 * fat_table_sb_pkg::TABLE_SIZE;

  logic                         clk;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_ready;
  logic [2:0]                   in_mode;
  logic [fca_pkg::LINK_W-1:0]   in_sector;
  logic [fca_pkg::LEN_W-1:0]    in_length;
  logic [fca_pkg::LINK_W-1:0]   in_value;
  logic                         out_valid;
  logic                         out_ready;
  logic [fca_pkg::LINK_W-1:0]   out_sector_out;
  logic [1:0]                   out_status;
  logic [fca_pkg::CNT_W-1:0]    out_free_count;
  logic                         out_last;

  fat_table_sb_pkg::fat_table_scoreboard tracker;
  int unsigned                           sent;
  bit                                    calm;
  int                                    chain_heads[$];

  fat_chain_allocator i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_mode        (in_mode),
    .in_sector      (in_sector),
    .in_length      (in_length),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_sector_out (out_sector_out),
    .out_status     (out_status),
    .out_free_count (out_free_count),
    .out_last       (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard limit: the worst case is every item a 16-sector allocate on a crowded table,
  // each result held off by the longest stall; allow about four times that.
  initial begin
    #200_000_000;
    $display("tb: failure");
    $finish;
  end

  // Sample result transfers with the values that stood before this edge.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      tracker.check_result(out_sector_out, out_status, out_free_count, out_last);
    end
  end

  // Result side: hold ready high for a random stretch, then stall; once the run turns calm, keep it high.
  initial begin : sink_pacing
    int unsigned n;
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 200) : $urandom_range(1, 40);
      repeat (n) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
      if (!calm) begin
        n = $urandom_range(1, 18);
        repeat (n) begin
          out_ready <= 1'b0;
          @(posedge clk);
        end
      end
    end
  end

  // Drop valid for a random burst now and then; callers sit just after a rising edge.
  task automatic idle_source();
    int unsigned n;
    if (!calm && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 18);
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Present one item, hold it until the transfer, then update the predicted table.
  task automatic send(logic [2:0] mode, logic [fca_pkg::LINK_W-1:0] sector,
                      logic [fca_pkg::LEN_W-1:0] length, logic [fca_pkg::LINK_W-1:0] value);
    idle_source();
    in_valid  <= 1'b1;
    in_mode   <= mode;
    in_sector <= sector;
    in_length <= length;
    in_value  <= value;
    do @(posedge clk); while (!in_ready);
    tracker.note_input(mode, sector, length, value);
    if (tracker.last_head >= 0) chain_heads.push_back(tracker.last_head);
    if (mode <= fca_pkg::MODE_FORMAT) sent++;
  endtask

  task automatic allocate(int unsigned length);
    send(fca_pkg::MODE_ALLOC, fca_pkg::LINK_W'($urandom), fca_pkg::LEN_W'(length),
         fca_pkg::LINK_W'($urandom));
  endtask

  task automatic free_chain(int unsigned start);
    send(fca_pkg::MODE_FREE, fca_pkg::LINK_W'(start), fca_pkg::LEN_W'($urandom),
         fca_pkg::LINK_W'($urandom));
  endtask

  task automatic read_next(int unsigned index);
    send(fca_pkg::MODE_NEXT, fca_pkg::LINK_W'(index), fca_pkg::LEN_W'($urandom),
         fca_pkg::LINK_W'($urandom));
  endtask

  task automatic load_link(int unsigned index, int unsigned link);
    send(fca_pkg::MODE_LOAD, fca_pkg::LINK_W'(index), fca_pkg::LEN_W'($urandom),
         fca_pkg::LINK_W'(link));
  endtask

  initial begin : stimulus
    int unsigned pick, len, idx, start, a, b, link, cur;
    bit          found;

    in_valid  <= 1'b0;
    in_mode   <= fca_pkg::MODE_NEXT;
    in_sector <= '0;
    in_length <= '0;
    in_value  <= '0;
    rst_n     <= 1'b0;
    tracker    = new();
    sent       = 0;
    calm       = 1'b0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: field extremes, every mode, the too-long and bad-index refusals and walk stops.
    read_next(0);                       // fresh table reads back as free
    allocate(0);                        // empty allocate
    allocate(fca_pkg::MAX_CHAIN + 1);   // just too long
    allocate(31);                       // longest length field
    allocate(fca_pkg::MAX_CHAIN);       // longest chain, sectors 0..15
    allocate(1);                        // single sector chain
    read_next(fca_pkg::MAX_CHAIN - 1);  // end marker at the chain tail
    read_next(fat_table_sb_pkg::TABLE_SIZE);  // first bad index
    read_next(16'hFFFF);                // top index
    free_chain(fca_pkg::LINK_FREE);     // free-marker start releases nothing
    free_chain(fca_pkg::LINK_END);      // end-marker start releases nothing
    free_chain(fat_table_sb_pkg::TABLE_SIZE); // start out of range
    free_chain(0);                      // full walk down to the end marker
    free_chain(0);                      // start already free
    load_link(300, 16'h1234);           // load at a bad index
    load_link(fat_table_sb_pkg::TABLE_SIZE - 1, 16'hABCD); // out-of-range link in the top entry
    free_chain(fat_table_sb_pkg::TABLE_SIZE - 1);          // walk stops at that link
    load_link(0, 2);                    // used entry pointing at a free one
    allocate(2);                        // claims 1 and 2; the lower entry 0 also leads there
    load_link(5, fca_pkg::LINK_END);    // free entry taken by a load
    load_link(5, fca_pkg::LINK_FREE);   // and given back
    send(3'd5, fca_pkg::LINK_W'($urandom), fca_pkg::LEN_W'($urandom),
         fca_pkg::LINK_W'($urandom));   // unknown mode
    send(3'd7, 16'hFFFF, 5'h1F, 16'hFFFF); // unknown mode
    send(fca_pkg::MODE_FORMAT, '0, '0, '0);
    read_next(fat_table_sb_pkg::TABLE_SIZE - 1);
    chain_heads.delete();

    // Random part: mostly allocate and free of tracked chains, with loads that build
    // odd links, chain reads, table fills and some noise.
    while (sent < ITEM_TARGET) begin
      calm = (sent >= CALM_AFTER);
      pick = $urandom_range(0, 99);
      if (pick < 28) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 6);
        allocate(len);
      end else if (pick < 48) begin
        if (chain_heads.size() != 0 && $urandom_range(0, 3) != 0) begin
          idx = $urandom_range(0, chain_heads.size() - 1);
          start = chain_heads[idx];
          chain_heads.delete(idx);
          free_chain(start);
        end else begin
          // release from a random used entry, mid-chain more often than not
          found = 1'b0;
          start = $urandom_range(0, fat_table_sb_pkg::TABLE_SIZE - 1);
          for (int k = 0; k < fat_table_sb_pkg::TABLE_SIZE && !found; k++) begin
            if (tracker.links[(start + k) % fat_table_sb_pkg::TABLE_SIZE] !=
                fca_pkg::LINK_FREE) begin
              start = (start + k) % fat_table_sb_pkg::TABLE_SIZE;
              found = 1'b1;
            end
          end
          free_chain(found ? start : $urandom_range(0, 16'hFFFF));
        end
      end else if (pick < 60) begin
        read_next(($urandom_range(0, 7) == 0) ? $urandom_range(0, 16'hFFFF)
                  : $urandom_range(0, fat_table_sb_pkg::TABLE_SIZE - 1));
      end else if (pick < 70) begin
        case ($urandom_range(0, 3))
          0:       link = fca_pkg::LINK_FREE;
          1:       link = fca_pkg::LINK_END;
          2:       link = $urandom_range(0, fat_table_sb_pkg::TABLE_SIZE - 1);
          default: link = $urandom_range(0, 16'hFFFF);
        endcase
        load_link(($urandom_range(0, 7) == 0) ? $urandom_range(0, 16'hFFFF)
                  : $urandom_range(0, fat_table_sb_pkg::TABLE_SIZE - 1), link);
      end else if (pick < 75) begin
        // two-entry loop; the walk must stop when it comes back to a freed entry
        a = $urandom_range(0, fat_table_sb_pkg::TABLE_SIZE - 1);
        b = (a + $urandom_range(1, fat_table_sb_pkg::TABLE_SIZE - 1)) %
            fat_table_sb_pkg::TABLE_SIZE;
        load_link(a, b);
        load_link(b, a);
        free_chain(a);
      end else if (pick < 81) begin
        send(3'($urandom_range(0, 7)), fca_pkg::LINK_W'($urandom), fca_pkg::LEN_W'($urandom),
             fca_pkg::LINK_W'($urandom));
      end else if (pick < 83 && !calm) begin
        // fill the table, then ask for one sector more than is left
        while (tracker.free_total >= fca_pkg::MAX_CHAIN) allocate(fca_pkg::MAX_CHAIN);
        allocate(tracker.free_total + 1);
      end else if (pick < 85) begin
        send(fca_pkg::MODE_FORMAT, fca_pkg::LINK_W'($urandom), fca_pkg::LEN_W'($urandom),
             fca_pkg::LINK_W'($urandom));
        chain_heads.delete();
      end else begin
        // allocate and follow the new chain link by link
        len = $urandom_range(1, 8);
        allocate(len);
        if (chain_heads.size() != 0 && tracker.last_head >= 0) begin
          cur = tracker.last_head;
          for (int k = 0; k < len && cur < fat_table_sb_pkg::TABLE_SIZE; k++) begin
            read_next(cur);
            cur = tracker.links[cur];
          end
        end
      end
    end

    in_valid <= 1'b0;
    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (tracker.mismatches == 0 && tracker.pending.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
